FILE: rtl/m7bg_pkg.sv
`default_nettype none

package m7bg_pkg;

  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    CMD_MAP_WR = 2'd0,
    CMD_CHR_WR = 2'd1,
    CMD_LINE   = 2'd2,
    CMD_PIXEL  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_A     = 3'd0,
    REG_MATRIX_B     = 3'd1,
    REG_MATRIX_C     = 3'd2,
    REG_MATRIX_D     = 3'd3,
    REG_CENTER_X     = 3'd4,
    REG_CENTER_Y     = 3'd5,
    REG_WRAP_MODE    = 3'd6,
    REG_SECOND_LAYER = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] WRAP_TRANSP = 2'd2;
  localparam logic [1:0] WRAP_TILE0  = 2'd3;

  typedef struct packed {
    logic signed [15:0] matrix_a;
    logic signed [15:0] matrix_b;
    logic signed [15:0] matrix_c;
    logic signed [15:0] matrix_d;
    logic signed [12:0] center_x;
    logic signed [12:0] center_y;
    logic        [1:0]  wrap_mode;
    logic               second_layer;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic [13:0]        addr;
    logic [7:0]         wbyte;
    logic [7:0]         line_y;
    logic signed [12:0] scroll_h;
    logic signed [12:0] scroll_v;
    logic [7:0]         pixel_x;
  } in_beat_t;

  // map position after the shift by eight, 24 significant bits
  typedef struct packed {
    logic        valid;
    cmd_t        cmd;
    logic [13:0] addr;
    logic [7:0]  wbyte;
    logic [23:0] px;
    logic [23:0] py;
  } xf_beat_t;

endpackage

`default_nettype wire

FILE: rtl/mode7_affine_background_fetch.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   command, store write, line start, column
// out_     output     out_valid/out_stall color_index, high_priority, transparent
// cfg_     input      cfg_valid/cfg_ready register index and 16-bit data
//
// One item per clock sustained while out_stall does not hold the pipe.
// Five stages: offsets/column products, line products, base sum and position,
// tile map read, character read; then the output register.
// Reset clears config, line bases and stage valids; stores are not cleared.
// A result held by out_stall halts the pipe only when another pixel has
// reached the last stage.
`default_nettype none

module mode7_affine_background_fetch
  import m7bg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_command,
  input  wire logic [13:0]           in_word_address,
  input  wire logic [7:0]            in_write_byte,
  input  wire logic [7:0]            in_line_y,
  input  wire logic signed [12:0]    in_scroll_h,
  input  wire logic signed [12:0]    in_scroll_v,
  input  wire logic [7:0]            in_pixel_x,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_color_index,
  output logic                       out_high_priority,
  output logic                       out_transparent,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MATRIX_A:     cfg_r.matrix_a     <= cfg_data;
        REG_MATRIX_B:     cfg_r.matrix_b     <= cfg_data;
        REG_MATRIX_C:     cfg_r.matrix_c     <= cfg_data;
        REG_MATRIX_D:     cfg_r.matrix_d     <= cfg_data;
        REG_CENTER_X:     cfg_r.center_x     <= cfg_data[12:0];
        REG_CENTER_Y:     cfg_r.center_y     <= cfg_data[12:0];
        REG_WRAP_MODE:    cfg_r.wrap_mode    <= cfg_data[1:0];
        REG_SECOND_LAYER: cfg_r.second_layer <= cfg_data[0];
      endcase
    end
  end

  logic     adv;
  in_beat_t in_beat;
  xf_beat_t xf_beat;

  assign in_stall = !adv;

  always_comb begin
    in_beat.valid    = in_valid;
    in_beat.cmd      = cmd_t'(in_command);
    in_beat.addr     = in_word_address;
    in_beat.wbyte    = in_write_byte;
    in_beat.line_y   = in_line_y;
    in_beat.scroll_h = in_scroll_h;
    in_beat.scroll_v = in_scroll_v;
    in_beat.pixel_x  = in_pixel_x;
  end

  m7bg_xform u_xform (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_beat(in_beat),
    .cfg    (cfg_r),
    .xf_beat(xf_beat)
  );

  m7bg_fetch u_fetch (
    .clk              (clk),
    .rst_n            (rst_n),
    .xf_beat          (xf_beat),
    .wrap_mode        (cfg_r.wrap_mode),
    .second_layer     (cfg_r.second_layer),
    .out_stall        (out_stall),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_color_index  (out_color_index),
    .out_high_priority(out_high_priority),
    .out_transparent  (out_transparent)
  );

endmodule

`default_nettype wire

FILE: rtl/m7bg_ram.sv
`default_nettype none

module m7bg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/m7bg_xform.sv
`default_nettype none

module m7bg_xform
  import m7bg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire in_beat_t in_beat,
  input  wire cfg_t     cfg,
  output xf_beat_t      xf_beat
);

  // stage 1: clipped offsets and column products
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic [13:0]        s1_addr_r;
  logic [7:0]         s1_wbyte_r;
  logic [7:0]         s1_y_r;
  logic signed [10:0] s1_ch_r;
  logic signed [10:0] s1_cv_r;
  logic signed [23:0] s1_pax_r;
  logic signed [23:0] s1_pcx_r;

  logic signed [13:0] dh;
  logic signed [13:0] dv;
  logic signed [24:0] pax_full;
  logic signed [24:0] pcx_full;

  assign dh = 14'(in_beat.scroll_h) - 14'(cfg.center_x);
  assign dv = 14'(in_beat.scroll_v) - 14'(cfg.center_y);
  assign pax_full = cfg.matrix_a * $signed({1'b0, in_beat.pixel_x});
  assign pcx_full = cfg.matrix_c * $signed({1'b0, in_beat.pixel_x});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r   <= in_beat.cmd;
      s1_addr_r  <= in_beat.addr;
      s1_wbyte_r <= in_beat.wbyte;
      s1_y_r     <= in_beat.line_y;
      s1_ch_r    <= {dh[13], dh[9:0]};
      s1_cv_r    <= {dv[13], dv[9:0]};
      s1_pax_r   <= pax_full[23:0];
      s1_pcx_r   <= pcx_full[23:0];
    end
  end

  // stage 2: line products, low six bits dropped
  logic               s2_valid_r;
  cmd_t               s2_cmd_r;
  logic [13:0]        s2_addr_r;
  logic [7:0]         s2_wbyte_r;
  logic signed [23:0] s2_pax_r;
  logic signed [23:0] s2_pcx_r;
  logic signed [20:0] s2_ach_r, s2_bcv_r, s2_by_r;
  logic signed [20:0] s2_cch_r, s2_dcv_r, s2_dy_r;

  logic signed [26:0] ach, bcv, by, cch, dcv, dy;

  assign ach = cfg.matrix_a * s1_ch_r;
  assign bcv = cfg.matrix_b * s1_cv_r;
  assign by  = cfg.matrix_b * $signed({1'b0, s1_y_r});
  assign cch = cfg.matrix_c * s1_ch_r;
  assign dcv = cfg.matrix_d * s1_cv_r;
  assign dy  = cfg.matrix_d * $signed({1'b0, s1_y_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_addr_r  <= s1_addr_r;
      s2_wbyte_r <= s1_wbyte_r;
      s2_pax_r   <= s1_pax_r;
      s2_pcx_r   <= s1_pcx_r;
      s2_ach_r   <= ach[26:6];
      s2_bcv_r   <= bcv[26:6];
      s2_by_r    <= by[26:6];
      s2_cch_r   <= cch[26:6];
      s2_dcv_r   <= dcv[26:6];
      s2_dy_r    <= dy[26:6];
    end
  end

  // stage 3: line base update, pixel position
  logic [31:0] line_base_x_r, line_base_y_r;
  logic [31:0] line_base_x_nxt, line_base_y_nxt;
  logic [31:0] sum_x, sum_y;

  assign line_base_x_nxt = {{5{s2_ach_r[20]}}, s2_ach_r, 6'd0}
                         + {{5{s2_bcv_r[20]}}, s2_bcv_r, 6'd0}
                         + {{5{s2_by_r[20]}}, s2_by_r, 6'd0}
                         + {{11{cfg.center_x[12]}}, cfg.center_x, 8'd0};
  assign line_base_y_nxt = {{5{s2_cch_r[20]}}, s2_cch_r, 6'd0}
                         + {{5{s2_dcv_r[20]}}, s2_dcv_r, 6'd0}
                         + {{5{s2_dy_r[20]}}, s2_dy_r, 6'd0}
                         + {{11{cfg.center_y[12]}}, cfg.center_y, 8'd0};

  assign sum_x = line_base_x_r + {{8{s2_pax_r[23]}}, s2_pax_r};
  assign sum_y = line_base_y_r + {{8{s2_pcx_r[23]}}, s2_pcx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_base_x_r <= '0;
      line_base_y_r <= '0;
    end else if (adv && s2_valid_r && s2_cmd_r == CMD_LINE) begin
      line_base_x_r <= line_base_x_nxt;
      line_base_y_r <= line_base_y_nxt;
    end
  end

  logic        s3_valid_r;
  cmd_t        s3_cmd_r;
  logic [13:0] s3_addr_r;
  logic [7:0]  s3_wbyte_r;
  logic [23:0] s3_px_r;
  logic [23:0] s3_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_addr_r  <= s2_addr_r;
      s3_wbyte_r <= s2_wbyte_r;
      s3_px_r    <= sum_x[31:8];
      s3_py_r    <= sum_y[31:8];
    end
  end

  always_comb begin
    xf_beat.valid = s3_valid_r;
    xf_beat.cmd   = s3_cmd_r;
    xf_beat.addr  = s3_addr_r;
    xf_beat.wbyte = s3_wbyte_r;
    xf_beat.px    = s3_px_r;
    xf_beat.py    = s3_py_r;
  end

endmodule

`default_nettype wire

FILE: rtl/m7bg_fetch.sv
`default_nettype none

module m7bg_fetch
  import m7bg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire xf_beat_t xf_beat,
  input  wire logic [1:0] wrap_mode,
  input  wire logic     second_layer,
  input  wire logic     out_stall,
  output logic          adv,
  output logic          out_valid,
  output logic [7:0]    out_color_index,
  output logic          out_high_priority,
  output logic          out_transparent
);

  // tile map: writes and reads both at this stage, so order is kept
  logic        outside;
  logic        tile_en;
  logic        tile_we;
  logic [13:0] tile_addr;
  logic [7:0]  tile_rdata;

  assign outside = (|xf_beat.px[23:10]) || (|xf_beat.py[23:10]);
  assign tile_we = xf_beat.cmd == CMD_MAP_WR;
  assign tile_en = adv && xf_beat.valid
                && (xf_beat.cmd == CMD_MAP_WR || xf_beat.cmd == CMD_PIXEL);
  assign tile_addr = tile_we ? xf_beat.addr : {xf_beat.py[9:3], xf_beat.px[9:3]};

  m7bg_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_tile_ram (
    .clk  (clk),
    .en   (tile_en),
    .we   (tile_we),
    .addr (tile_addr),
    .wdata(xf_beat.wbyte),
    .rdata(tile_rdata)
  );

  logic        s4_valid_r;
  cmd_t        s4_cmd_r;
  logic [13:0] s4_addr_r;
  logic [7:0]  s4_wbyte_r;
  logic        s4_zero_tile_r;
  logic        s4_transp_r;
  logic [5:0]  s4_fine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= xf_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cmd_r       <= xf_beat.cmd;
      s4_addr_r      <= xf_beat.addr;
      s4_wbyte_r     <= xf_beat.wbyte;
      s4_zero_tile_r <= outside && wrap_mode == WRAP_TILE0;
      s4_transp_r    <= outside && wrap_mode == WRAP_TRANSP;
      s4_fine_r      <= {xf_beat.py[2:0], xf_beat.px[2:0]};
    end
  end

  // character store
  logic [7:0]  tile;
  logic        chr_en;
  logic        chr_we;
  logic [13:0] chr_addr;
  logic [7:0]  chr_rdata;

  assign tile     = s4_zero_tile_r ? 8'd0 : tile_rdata;
  assign chr_we   = s4_cmd_r == CMD_CHR_WR;
  assign chr_en   = adv && s4_valid_r
                 && (s4_cmd_r == CMD_CHR_WR || s4_cmd_r == CMD_PIXEL);
  assign chr_addr = chr_we ? s4_addr_r : {tile, s4_fine_r};

  m7bg_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_chr_ram (
    .clk  (clk),
    .en   (chr_en),
    .we   (chr_we),
    .addr (chr_addr),
    .wdata(s4_wbyte_r),
    .rdata(chr_rdata)
  );

  logic s5_pix_r;
  logic s5_transp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_pix_r <= 1'b0;
    end else if (adv) begin
      s5_pix_r <= s4_valid_r && s4_cmd_r == CMD_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_transp_r <= s4_transp_r;
    end
  end

  // pipe only halts when a pixel in the last stage meets a held result
  logic       out_valid_r;
  logic [7:0] out_index_r;
  logic       out_prio_r;
  logic       out_transp_r;
  logic [7:0] pix;
  logic [7:0] index_nxt;
  logic       prio_nxt;

  assign adv = !(s5_pix_r && out_valid_r && out_stall);

  always_comb begin
    pix       = s5_transp_r ? 8'd0 : chr_rdata;
    index_nxt = pix;
    prio_nxt  = 1'b0;
    if (second_layer) begin
      index_nxt = {1'b0, pix[6:0]};
      prio_nxt  = pix[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s5_pix_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s5_pix_r) begin
      out_index_r  <= index_nxt;
      out_prio_r   <= prio_nxt;
      out_transp_r <= index_nxt == 8'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_color_index   = out_index_r;
  assign out_high_priority = out_prio_r;
  assign out_transparent   = out_transp_r;

  a_hold_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> out_valid_r)
    else $error("pipe held without a waiting result");

  a_no_ram_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> (!tile_en && !chr_en))
    else $error("store accessed while pipe held");

  a_outside_transp: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s5_pix_r && s5_transp_r) |=> (out_valid_r && out_transp_r
      && out_index_r == 8'd0 && !out_prio_r))
    else $error("outside pixel not transparent");

  a_transp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_transp_r == (out_index_r == 8'd0)))
    else $error("transparent flag disagrees with index");

endmodule

`default_nettype wire
